### src/process_slot_allocator_scheduler_top_assert.svh
// Assertion macros used by the checker of the process slot allocator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PROCESS_SLOT_ALLOCATOR_SCHEDULER_TOP_ASSERT_SVH
`define PROCESS_SLOT_ALLOCATOR_SCHEDULER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/psa_pkg.sv
`timescale 1ns / 1ps

package psa_pkg;

  localparam int FIELD_W     = 16;
  localparam int PID_W       = 8;
  localparam int MAGIC_W     = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int HOOK_W      = 2;
  localparam int SLOT_W      = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Input tdata layout, lowest bit first.
  localparam int IN_PID_LSB    = 0;
  localparam int IN_MAGIC_LSB  = IN_PID_LSB + PID_W;
  localparam int IN_FSIZE_LSB  = IN_MAGIC_LSB + MAGIC_W;
  localparam int IN_RSIZE_LSB  = IN_FSIZE_LSB + FIELD_W;
  localparam int IN_START_LSB  = IN_RSIZE_LSB + FIELD_W;
  localparam int IN_PROC_LSB   = IN_START_LSB + FIELD_W;
  localparam int IN_EXIT_LSB   = IN_PROC_LSB + FIELD_W;
  localparam int IN_TDATA_W    = IN_EXIT_LSB + FIELD_W;

  // Output tdata layout, lowest bit first, padded to whole bytes.
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_SLOT_LSB   = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_HOOK_LSB   = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_ADDR_LSB   = OUT_HOOK_LSB + HOOK_W;
  localparam int OUT_LOC_LSB    = OUT_ADDR_LSB + FIELD_W;
  localparam int OUT_USED_W     = OUT_LOC_LSB + FIELD_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_USED_W;

  // Four header bytes of a valid image, first byte in the top bits.
  localparam logic [MAGIC_W-1:0] HEADER_MAGIC = {8'h42, 8'h52, 8'h4F, 8'h53};

  localparam logic [CFG_DATA_W-1:0] APP_RAM_SIZE_RESET = 16'd8192;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_EXIT   = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_LOADED = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_HEADER = 2'd1,
    STAT_NO_MEM     = 2'd2,
    STAT_BAD_PID    = 2'd3
  } status_t;

  typedef enum logic [HOOK_W-1:0] {
    HOOK_NONE  = 2'd0,
    HOOK_START = 2'd1,
    HOOK_PROC  = 2'd2,
    HOOK_EXIT  = 2'd3
  } hook_t;

  typedef enum logic [2:0] {
    SS_INACTIVE   = 3'd0,
    SS_LOADING    = 3'd1,
    SS_LOADED     = 3'd2,
    SS_RUNNING    = 3'd3,
    SS_AWAIT_EXIT = 3'd4
  } slot_state_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_APP_RAM_BASE = 1'b0,
    REG_APP_RAM_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_ALLOC_CHK,
    FSM_ALLOC_RD,
    FSM_ALLOC_EV,
    FSM_ALLOC_END,
    FSM_ALLOC_WR,
    FSM_RUN_RD,
    FSM_RUN_EV,
    FSM_PID
  } fsm_t;

  typedef struct packed {
    logic fld_we;
    logic st_we;
  } tbl_ctrl_t;

endpackage

### src/psa_slot_table.sv
`timescale 1ns / 1ps

module psa_slot_table #(
  parameter int NUM_SLOTS  = 8,
  parameter int ADDR_WIDTH = 16,
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psa_pkg::tbl_ctrl_t           ctrl,
  input  logic [IDX_W-1:0]             idx,
  input  psa_pkg::slot_state_t         st_wdata,
  output psa_pkg::slot_state_t         st_rdata,
  input  logic [ADDR_WIDTH-1:0]        base_wdata,
  input  logic [psa_pkg::FIELD_W-1:0]  len_wdata,
  input  logic [ADDR_WIDTH-1:0]        start_wdata,
  input  logic [ADDR_WIDTH-1:0]        proc_wdata,
  input  logic [ADDR_WIDTH-1:0]        exit_wdata,
  output logic [ADDR_WIDTH-1:0]        base_rdata,
  output logic [psa_pkg::FIELD_W-1:0]  len_rdata,
  output logic [ADDR_WIDTH-1:0]        start_rdata,
  output logic [ADDR_WIDTH-1:0]        proc_rdata,
  output logic [ADDR_WIDTH-1:0]        exit_rdata
);
  import psa_pkg::*;

  localparam int ENTRY_W = 4 * ADDR_WIDTH + FIELD_W;

  // Lifecycle state lives in flops so that reset can mark every slot inactive.
  slot_state_t state_r [NUM_SLOTS];

  // Location, length and hook addresses share one single-port memory.
  logic [ENTRY_W-1:0] mem_r [NUM_SLOTS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] wr_data;

  assign wr_data  = {exit_wdata, proc_wdata, start_wdata, len_wdata, base_wdata};
  assign st_rdata = state_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_r[i] <= SS_INACTIVE;
      end
    end else if (ctrl.st_we) begin
      state_r[idx] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fld_we) begin
      mem_r[idx] <= wr_data;
    end
    rd_data_r <= mem_r[idx];
  end

  assign base_rdata  = rd_data_r[ADDR_WIDTH-1:0];
  assign len_rdata   = rd_data_r[ADDR_WIDTH +: FIELD_W];
  assign start_rdata = rd_data_r[ADDR_WIDTH + FIELD_W +: ADDR_WIDTH];
  assign proc_rdata  = rd_data_r[2 * ADDR_WIDTH + FIELD_W +: ADDR_WIDTH];
  assign exit_rdata  = rd_data_r[3 * ADDR_WIDTH + FIELD_W +: ADDR_WIDTH];

endmodule

### src/process_slot_allocator_scheduler_top.sv
`timescale 1ns / 1ps

// First-fit process table of NUM_SLOTS slots. The block takes one request at a
// time and drops in_tready from the transfer until its last result is loaded
// into the output register; the next request may be taken while that result
// still waits. Slot records sit in a memory with one registered read port, so
// every slot visited takes a read state and an evaluate state. An allocation
// first checks the header and size and gives an error result if either fails.
// It then scans the table and, when it finds room in a gap before an active
// slot or, after the scan, in the gap at the end of RAM, writes the request
// into that slot; else it gives a no-memory result. A run pass gives one result
// per slot, the final one with tlast set; exit and mark-loaded requests each
// give one result. Result-side stalls hold back every step that loads a result.
module process_slot_allocator_scheduler_top #(
  parameter int NUM_SLOTS  = 8,
  parameter int ADDR_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pid, magic, file_size, ram_size, start_offset, proc_offset, exit_offset
  input  logic [psa_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode
  input  logic [psa_pkg::MODE_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, slot, hook, hook_address, location, zero padding
  output logic [psa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [psa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [psa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import psa_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EW    = (ADDR_WIDTH > FIELD_W) ? ADDR_WIDTH : FIELD_W;
  localparam int OFF_W = FIELD_W + IDX_W;
  localparam int CMP_W = ((EW > OFF_W) ? EW : OFF_W) + 1;

  // Configuration
  logic [CFG_DATA_W-1:0] app_ram_base_r;
  logic [CFG_DATA_W-1:0] app_ram_size_r;

  // Sequencer
  fsm_t fsm_r, fsm_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic             cand_v_r, cand_v_nxt;
  logic [IDX_W-1:0] cand_idx_r, cand_idx_nxt;
  logic [OFF_W-1:0] cand_off_r, cand_off_nxt;

  // Request held for the whole operation
  mode_t              mode_r;
  logic [PID_W-1:0]   pid_r;
  logic [MAGIC_W-1:0] magic_r;
  logic [FIELD_W-1:0] file_size_r;
  logic [FIELD_W-1:0] ram_size_r;
  logic [FIELD_W-1:0] start_off_r;
  logic [FIELD_W-1:0] proc_off_r;
  logic [FIELD_W-1:0] exit_off_r;

  // Output register
  logic               out_valid_r;
  logic               out_load;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  hook_t              out_hook_r, out_hook_nxt;
  logic [FIELD_W-1:0] out_addr_r, out_addr_nxt;
  logic [FIELD_W-1:0] out_loc_r, out_loc_nxt;
  logic               out_last_r, out_last_nxt;

  // Slot table
  tbl_ctrl_t             tbl_ctrl;
  logic [IDX_W-1:0]      tbl_idx;
  slot_state_t           st_wdata;
  slot_state_t           st_rdata;
  logic [ADDR_WIDTH-1:0] base_rd, start_rd, proc_rd, exit_rd;
  logic [FIELD_W-1:0]    len_rd;

  // Datapath
  logic                  in_acc;
  logic                  out_free;
  logic                  hdr_ok;
  logic [FIELD_W:0]      need;
  logic                  need_fail;
  logic                  last_idx;
  logic                  pid_ok;
  logic [ADDR_WIDTH-1:0] rel_base;
  logic [EW-1:0]         fit_end;
  logic [CMP_W-1:0]      fit_end_x, fit_off_x;
  logic                  fits;
  logic [ADDR_WIDTH-1:0] loc;
  logic [ADDR_WIDTH-1:0] start_addr, proc_addr, exit_addr;

  function automatic logic [ADDR_WIDTH-1:0] hook_addr(input logic [ADDR_WIDTH-1:0] base,
                                                       input logic [FIELD_W-1:0] off);
    hook_addr = (off == '0) ? '0 : base + ADDR_WIDTH'(off);
  endfunction

  assign in_tready = (fsm_r == FSM_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_ram_base_r <= '0;
      app_ram_size_r <= APP_RAM_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_APP_RAM_BASE: app_ram_base_r <= cfg_wdata;
        REG_APP_RAM_SIZE: app_ram_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r      <= mode_t'(in_tuser);
      pid_r       <= in_tdata[IN_PID_LSB +: PID_W];
      magic_r     <= in_tdata[IN_MAGIC_LSB +: MAGIC_W];
      file_size_r <= in_tdata[IN_FSIZE_LSB +: FIELD_W];
      ram_size_r  <= in_tdata[IN_RSIZE_LSB +: FIELD_W];
      start_off_r <= in_tdata[IN_START_LSB +: FIELD_W];
      proc_off_r  <= in_tdata[IN_PROC_LSB +: FIELD_W];
      exit_off_r  <= in_tdata[IN_EXIT_LSB +: FIELD_W];
    end
  end

  // Shared datapath: one fit check, one location adder and the hook adders.
  always_comb begin
    hdr_ok    = (magic_r == HEADER_MAGIC);
    need      = (FIELD_W + 1)'(file_size_r) + (FIELD_W + 1)'(ram_size_r);
    need_fail = (need > (FIELD_W + 1)'(app_ram_size_r));
    last_idx  = (cnt_r == IDX_W'(NUM_SLOTS - 1));
    pid_ok    = (pid_r < PID_W'(NUM_SLOTS));

    // The slot base relative to the RAM start wraps at the address width.
    rel_base = base_rd - ADDR_WIDTH'(app_ram_base_r);

    // The gap ends at the next active slot, or at the end of RAM after the scan.
    if (fsm_r == FSM_ALLOC_END) begin
      fit_end = EW'(app_ram_size_r);
    end else begin
      fit_end = EW'(rel_base);
    end
    fit_end_x = CMP_W'(fit_end);
    fit_off_x = CMP_W'(cand_off_r);
    fits      = (fit_end_x >= fit_off_x) && ((fit_end_x - fit_off_x) >= CMP_W'(need));

    loc        = ADDR_WIDTH'(app_ram_base_r) + ADDR_WIDTH'(cand_off_r);
    start_addr = hook_addr(loc, start_off_r);
    proc_addr  = hook_addr(loc, proc_off_r);
    exit_addr  = hook_addr(loc, exit_off_r);
  end

  always_comb begin
    case (fsm_r)
      FSM_ALLOC_WR: tbl_idx = cand_idx_r;
      FSM_PID:      tbl_idx = pid_r[IDX_W-1:0];
      default:      tbl_idx = cnt_r;
    endcase
  end

  always_comb begin : next_state
    fsm_nxt = fsm_r;
    case (fsm_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          case (mode_t'(in_tuser))
            MODE_ALLOC: fsm_nxt = FSM_ALLOC_CHK;
            MODE_RUN:   fsm_nxt = FSM_RUN_RD;
            default:    fsm_nxt = FSM_PID;
          endcase
        end
      end
      FSM_ALLOC_CHK: begin
        if (!hdr_ok || need_fail) begin
          if (out_free) fsm_nxt = FSM_IDLE;
        end else begin
          fsm_nxt = FSM_ALLOC_RD;
        end
      end
      FSM_ALLOC_RD: fsm_nxt = FSM_ALLOC_EV;
      FSM_ALLOC_EV: begin
        if (st_rdata != SS_INACTIVE && cand_v_r && fits) begin
          fsm_nxt = FSM_ALLOC_WR;
        end else if (last_idx) begin
          fsm_nxt = FSM_ALLOC_END;
        end else begin
          fsm_nxt = FSM_ALLOC_RD;
        end
      end
      FSM_ALLOC_END: begin
        if (cand_v_r && fits) begin
          fsm_nxt = FSM_ALLOC_WR;
        end else if (out_free) begin
          fsm_nxt = FSM_IDLE;
        end
      end
      FSM_ALLOC_WR: begin
        if (out_free) fsm_nxt = FSM_IDLE;
      end
      FSM_RUN_RD: fsm_nxt = FSM_RUN_EV;
      FSM_RUN_EV: begin
        if (out_free) fsm_nxt = last_idx ? FSM_IDLE : FSM_RUN_RD;
      end
      FSM_PID: begin
        if (out_free) fsm_nxt = FSM_IDLE;
      end
      default: fsm_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin : outputs
    cnt_nxt        = cnt_r;
    offset_nxt     = offset_r;
    cand_v_nxt     = cand_v_r;
    cand_idx_nxt   = cand_idx_r;
    cand_off_nxt   = cand_off_r;
    tbl_ctrl       = '0;
    st_wdata       = SS_INACTIVE;
    out_load       = 1'b0;
    out_status_nxt = STAT_OK;
    out_slot_nxt   = '0;
    out_hook_nxt   = HOOK_NONE;
    out_addr_nxt   = '0;
    out_loc_nxt    = '0;
    out_last_nxt   = 1'b1;

    case (fsm_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt    = '0;
          offset_nxt = '0;
          cand_v_nxt = 1'b0;
        end
      end
      FSM_ALLOC_CHK: begin
        if (!hdr_ok || need_fail) begin
          out_load       = out_free;
          out_status_nxt = hdr_ok ? STAT_NO_MEM : STAT_BAD_HEADER;
        end
      end
      FSM_ALLOC_EV: begin
        // Inactive slots in one run share the same gap, so the first one of
        // the run is the only candidate worth keeping.
        if (st_rdata == SS_INACTIVE) begin
          if (!cand_v_r) begin
            cand_v_nxt   = 1'b1;
            cand_idx_nxt = cnt_r;
            cand_off_nxt = offset_r;
          end
        end else begin
          if (cand_v_r && !fits) cand_v_nxt = 1'b0;
          offset_nxt = offset_r + OFF_W'(len_rd);
        end
        if (!last_idx) cnt_nxt = cnt_r + 1'b1;
      end
      FSM_ALLOC_END: begin
        if (!(cand_v_r && fits)) begin
          out_load       = out_free;
          out_status_nxt = STAT_NO_MEM;
        end
      end
      FSM_ALLOC_WR: begin
        if (out_free) begin
          tbl_ctrl.fld_we = 1'b1;
          tbl_ctrl.st_we  = 1'b1;
          st_wdata        = SS_LOADING;
          out_load        = 1'b1;
        end
        out_slot_nxt = SLOT_W'(cand_idx_r);
        out_loc_nxt  = FIELD_W'(loc);
      end
      FSM_RUN_EV: begin
        out_slot_nxt = SLOT_W'(cnt_r);
        out_last_nxt = last_idx;
        st_wdata     = st_rdata;
        case (st_rdata)
          SS_LOADED: begin
            if (start_rd != '0) begin
              out_hook_nxt = HOOK_START;
              out_addr_nxt = FIELD_W'(start_rd);
            end
            st_wdata = SS_RUNNING;
          end
          SS_RUNNING: begin
            if (proc_rd != '0) begin
              out_hook_nxt = HOOK_PROC;
              out_addr_nxt = FIELD_W'(proc_rd);
            end else begin
              st_wdata = SS_AWAIT_EXIT;
            end
          end
          SS_AWAIT_EXIT: begin
            if (exit_rd != '0) begin
              out_hook_nxt = HOOK_EXIT;
              out_addr_nxt = FIELD_W'(exit_rd);
            end
            st_wdata = SS_INACTIVE;
          end
          default: ;
        endcase
        if (out_free) begin
          out_load       = 1'b1;
          tbl_ctrl.st_we = (st_wdata != st_rdata);
          if (!last_idx) cnt_nxt = cnt_r + 1'b1;
        end
      end
      FSM_PID: begin
        out_slot_nxt   = pid_r;
        out_status_nxt = pid_ok ? STAT_OK : STAT_BAD_PID;
        out_load       = out_free;
        if (mode_r == MODE_EXIT) begin
          st_wdata = SS_AWAIT_EXIT;
          tbl_ctrl.st_we = out_free && pid_ok && (st_rdata != SS_INACTIVE);
        end else begin
          st_wdata = SS_LOADED;
          tbl_ctrl.st_we = out_free && pid_ok && (st_rdata == SS_LOADING);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r      <= FSM_IDLE;
      cand_v_r   <= 1'b0;
      cnt_r      <= '0;
      offset_r   <= '0;
    end else begin
      fsm_r      <= fsm_nxt;
      cand_v_r   <= cand_v_nxt;
      cnt_r      <= cnt_nxt;
      offset_r   <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_idx_r <= cand_idx_nxt;
    cand_off_r <= cand_off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_hook_r   <= out_hook_nxt;
      out_addr_r   <= out_addr_nxt;
      out_loc_r    <= out_loc_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_loc_r, out_addr_r, out_hook_r, out_slot_r,
                       out_status_r};

  psa_slot_table #(
    .NUM_SLOTS  (NUM_SLOTS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (tbl_ctrl),
    .idx         (tbl_idx),
    .st_wdata    (st_wdata),
    .st_rdata    (st_rdata),
    .base_wdata  (loc),
    .len_wdata   (FIELD_W'(need)),
    .start_wdata (start_addr),
    .proc_wdata  (proc_addr),
    .exit_wdata  (exit_addr),
    .base_rdata  (base_rd),
    .len_rdata   (len_rd),
    .start_rdata (start_rd),
    .proc_rdata  (proc_rd),
    .exit_rdata  (exit_rd)
  );

endmodule

### src/psa_checker.sv
`timescale 1ns / 1ps
`include "process_slot_allocator_scheduler_top_assert.svh"

module psa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [psa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import psa_pkg::*;

  // A request occupies the block, so it never takes two transfers back to back.
  `PSA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // Error results are single results with no hook and no location.
  `PSA_ASSERT_IMPLY(a_error_result, out_tvalid && (out_tdata[OUT_STATUS_LSB +: STATUS_W] != STAT_OK), out_tlast && (out_tdata[OUT_HOOK_LSB +: HOOK_W] == HOOK_NONE) && (out_tdata[OUT_LOC_LSB +: FIELD_W] == '0), "error result carries hook or location")

  `PSA_ASSERT_IMPLY(a_no_hook_no_addr, out_tvalid && (out_tdata[OUT_HOOK_LSB +: HOOK_W] == HOOK_NONE), out_tdata[OUT_ADDR_LSB +: FIELD_W] == '0, "hook address without a hook")

  `PSA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

endmodule

bind process_slot_allocator_scheduler_top psa_checker u_psa_checker (.*);

### dv/process_slot_allocator_scheduler_top_test.sv
`timescale 1ns / 1ps

module process_slot_allocator_scheduler_top_test;
  import psa_pkg::*;

  localparam int SLOTS        = 8;
  localparam int RUN_PHASES   = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  typedef struct {
    mode_t                mode;
    logic [PID_W-1:0]     pid;
    logic [MAGIC_W-1:0]   magic;
    logic [FIELD_W-1:0]   file_size;
    logic [FIELD_W-1:0]   ram_size;
    logic [FIELD_W-1:0]   start_off;
    logic [FIELD_W-1:0]   proc_off;
    logic [FIELD_W-1:0]   exit_off;
  } sched_req_t;

  typedef struct {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    hook_t                hook;
    logic [FIELD_W-1:0]   hook_addr;
    logic [FIELD_W-1:0]   location;
    logic                 last;
  } sched_result_t;

  typedef struct {
    logic                  is_cfg;
    cfg_reg_t              cfg_reg;
    logic [CFG_DATA_W-1:0] cfg_val;
    sched_req_t            req;
    logic                  typed;
    sched_result_t         want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  logic calm       = 1'b0;
  logic hold_start = 1'b0;

  // Shadow copy of the process table and the RAM window.
  logic [FIELD_W-1:0] ram_base_q;
  logic [FIELD_W-1:0] ram_size_q;
  slot_state_t        tbl_state [SLOTS];
  logic [FIELD_W-1:0] tbl_base  [SLOTS];
  logic [FIELD_W-1:0] tbl_len   [SLOTS];
  logic [FIELD_W-1:0] tbl_start [SLOTS];
  logic [FIELD_W-1:0] tbl_proc  [SLOTS];
  logic [FIELD_W-1:0] tbl_exit  [SLOTS];

  sched_result_t step_results[$];
  sched_result_t pending_results[$];

  int fail_count  = 0;
  int checked     = 0;
  int accepted    = 0;
  int granted     = 0;
  int refused     = 0;
  int passes      = 0;
  int cfg_writes  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  process_slot_allocator_scheduler_top #(
    .NUM_SLOTS (SLOTS),
    .ADDR_WIDTH(FIELD_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 30) begin
      $display("MISMATCH at %0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      report_mismatch(what, want, got);
    end
  endtask

  function automatic sched_result_t make_result(status_t st, logic [SLOT_W-1:0] slot,
      hook_t hk, logic [FIELD_W-1:0] addr, logic [FIELD_W-1:0] loc, logic last);
    sched_result_t r;
    r.status    = st;
    r.slot      = slot;
    r.hook      = hk;
    r.hook_addr = addr;
    r.location  = loc;
    r.last      = last;
    return r;
  endfunction

  // A zero offset means no hook; otherwise the address wraps at the address width.
  function automatic logic [FIELD_W-1:0] hook_target(logic [FIELD_W-1:0] loc,
      logic [FIELD_W-1:0] off);
    logic [FIELD_W-1:0] addr;
    addr = loc + off;
    return (off == '0) ? '0 : addr;
  endfunction

  function automatic void predict_allocate(sched_req_t req);
    logic [31:0]        need;
    logic [31:0]        offset;
    logic [31:0]        gap_end;
    logic [FIELD_W-1:0] rel;
    logic [FIELD_W-1:0] loc;
    logic               placed;
    logic               found;
    need   = req.file_size + req.ram_size;
    offset = '0;
    placed = 1'b0;
    if (req.magic != HEADER_MAGIC) begin
      refused++;
      step_results.push_back(make_result(STAT_BAD_HEADER, '0, HOOK_NONE, '0, '0, 1'b1));
      return;
    end
    if (need > ram_size_q) begin
      refused++;
      step_results.push_back(make_result(STAT_NO_MEM, '0, HOOK_NONE, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < SLOTS && !placed; i++) begin
      if (tbl_state[i] != SS_INACTIVE) begin
        offset += tbl_len[i];
      end else begin
        gap_end = ram_size_q;
        found   = 1'b0;
        for (int j = i + 1; j < SLOTS; j++) begin
          if (!found && tbl_state[j] != SS_INACTIVE) begin
            rel     = tbl_base[j] - ram_base_q;
            gap_end = rel;
            found   = 1'b1;
          end
        end
        // A gap that would be negative is simply no room.
        if (gap_end >= offset && gap_end - offset >= need) begin
          loc          = ram_base_q + offset[FIELD_W-1:0];
          tbl_base[i]  = loc;
          tbl_len[i]   = need[FIELD_W-1:0];
          tbl_start[i] = hook_target(loc, req.start_off);
          tbl_proc[i]  = hook_target(loc, req.proc_off);
          tbl_exit[i]  = hook_target(loc, req.exit_off);
          tbl_state[i] = SS_LOADING;
          placed       = 1'b1;
          granted++;
          step_results.push_back(make_result(STAT_OK, SLOT_W'(i), HOOK_NONE, '0, loc, 1'b1));
        end
      end
    end
    if (!placed) begin
      refused++;
      step_results.push_back(make_result(STAT_NO_MEM, '0, HOOK_NONE, '0, '0, 1'b1));
    end
  endfunction

  function automatic void predict_run();
    hook_t              hk;
    logic [FIELD_W-1:0] addr;
    passes++;
    for (int i = 0; i < SLOTS; i++) begin
      hk   = HOOK_NONE;
      addr = '0;
      case (tbl_state[i])
        SS_LOADED: begin
          if (tbl_start[i] != '0) begin
            hk   = HOOK_START;
            addr = tbl_start[i];
          end
          tbl_state[i] = SS_RUNNING;
        end
        SS_RUNNING: begin
          if (tbl_proc[i] != '0) begin
            hk   = HOOK_PROC;
            addr = tbl_proc[i];
          end else begin
            tbl_state[i] = SS_AWAIT_EXIT;
          end
        end
        SS_AWAIT_EXIT: begin
          if (tbl_exit[i] != '0) begin
            hk   = HOOK_EXIT;
            addr = tbl_exit[i];
          end
          tbl_state[i] = SS_INACTIVE;
        end
        default: ;
      endcase
      step_results.push_back(make_result(STAT_OK, SLOT_W'(i), hk, addr, '0, i == SLOTS - 1));
    end
  endfunction

  function automatic void predict_pid_request(sched_req_t req);
    if (req.pid >= SLOTS) begin
      step_results.push_back(make_result(STAT_BAD_PID, req.pid, HOOK_NONE, '0, '0, 1'b1));
      return;
    end
    if (req.mode == MODE_EXIT) begin
      if (tbl_state[req.pid] != SS_INACTIVE) begin
        tbl_state[req.pid] = SS_AWAIT_EXIT;
      end
    end else if (tbl_state[req.pid] == SS_LOADING) begin
      tbl_state[req.pid] = SS_LOADED;
    end
    step_results.push_back(make_result(STAT_OK, req.pid, HOOK_NONE, '0, '0, 1'b1));
  endfunction

  function automatic void predict_step(sched_req_t req);
    step_results.delete();
    case (req.mode)
      MODE_ALLOC: predict_allocate(req);
      MODE_RUN:   predict_run();
      default:    predict_pid_request(req);
    endcase
  endfunction

  function automatic plan_row_t item_row(mode_t m, logic [PID_W-1:0] pid,
      logic [MAGIC_W-1:0] magic, logic [FIELD_W-1:0] fsz, rsz, so, po, eo);
    plan_row_t r;
    r.is_cfg        = 1'b0;
    r.typed         = 1'b0;
    r.req.mode      = m;
    r.req.pid       = pid;
    r.req.magic     = magic;
    r.req.file_size = fsz;
    r.req.ram_size  = rsz;
    r.req.start_off = so;
    r.req.proc_off  = po;
    r.req.exit_off  = eo;
    return r;
  endfunction

  function automatic plan_row_t typed_row(plan_row_t r, status_t st, logic [SLOT_W-1:0] slot,
      logic [FIELD_W-1:0] loc);
    r.typed = 1'b1;
    r.want  = make_result(st, slot, HOOK_NONE, '0, loc, 1'b1);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.cfg_reg = idx;
    r.cfg_val = val;
    r.typed   = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) >= 27) begin
      return 0;
    end
    return $urandom_range(1, 5);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_offset(logic [FIELD_W-1:0] image_size);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return FIELD_W'($urandom_range(1, int'(image_size) + 1));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Prefer a slot that the request can act on, so lifecycles run to the end.
  function automatic logic [PID_W-1:0] pick_slot(slot_state_t st, logic any_active);
    int hits[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (any_active ? (tbl_state[i] != SS_INACTIVE) : (tbl_state[i] == st)) begin
        hits.push_back(i);
      end
    end
    if (hits.size() != 0 && $urandom_range(0, 9) < 8) begin
      return PID_W'(hits[$urandom_range(0, hits.size() - 1)]);
    end
    return PID_W'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic sched_req_t random_request();
    sched_req_t r;
    int         roll;
    r.mode      = mode_t'($urandom_range(0, 3));
    r.pid       = PID_W'($urandom);
    r.magic     = $urandom;
    r.file_size = FIELD_W'($urandom);
    r.ram_size  = FIELD_W'($urandom);
    r.start_off = FIELD_W'($urandom);
    r.proc_off  = FIELD_W'($urandom);
    r.exit_off  = FIELD_W'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 1) begin
        r.magic = HEADER_MAGIC ^ (32'd1 << $urandom_range(0, 31));
      end
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      r.mode      = MODE_ALLOC;
      r.magic     = HEADER_MAGIC;
      r.file_size = FIELD_W'($urandom_range(0, ram_size_q / 6));
      r.ram_size  = FIELD_W'($urandom_range(0, ram_size_q / 6));
      r.start_off = pick_offset(r.file_size);
      r.proc_off  = pick_offset(r.file_size);
      r.exit_off  = pick_offset(r.file_size);
    end else if (roll < 60) begin
      r.mode = MODE_LOADED;
      r.pid  = pick_slot(SS_LOADING, 1'b0);
    end else if (roll < 82) begin
      r.mode = MODE_RUN;
    end else begin
      r.mode = MODE_EXIT;
      r.pid  = pick_slot(SS_INACTIVE, 1'b1);
    end
    return r;
  endfunction

  task automatic send_request(sched_req_t req, int gap, logic typed, sched_result_t want);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.mode;
    in_tdata  <= {req.exit_off, req.proc_off, req.start_off, req.ram_size, req.file_size,
                  req.magic, req.pid};
    do @(posedge clk); while (!in_tready);
    accepted++;
    predict_step(req);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    if (idx == REG_APP_RAM_BASE) begin
      ram_base_q = val;
    end else begin
      ram_size_q = val;
    end
  endtask

  task automatic wait_drained(int extra);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, tdata low bits", '0, out_tdata[31:0]);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_tdata[OUT_STATUS_LSB +: STATUS_W]);
        check_field("slot", want.slot, out_tdata[OUT_SLOT_LSB +: SLOT_W]);
        check_field("hook", want.hook, out_tdata[OUT_HOOK_LSB +: HOOK_W]);
        check_field("hook_address", want.hook_addr, out_tdata[OUT_ADDR_LSB +: FIELD_W]);
        check_field("location", want.location, out_tdata[OUT_LOC_LSB +: FIELD_W]);
        check_field("tlast", want.last, out_tlast);
        check_field("padding", '0, out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
      end
    end
  end

  // Result side: random back-pressure, one long hold-off on request, none while calm.
  initial begin : result_sink
    int   hold_left;
    logic hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    plan_row_t     plan[$];
    sched_result_t no_result;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    no_result = make_result(STAT_OK, '0, HOOK_NONE, '0, '0, 1'b0);
    ram_base_q = '0;
    ram_size_q = APP_RAM_SIZE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_state[i] = SS_INACTIVE;
      tbl_base[i]  = '0;
      tbl_len[i]   = '0;
      tbl_start[i] = '0;
      tbl_proc[i]  = '0;
      tbl_exit[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header and size rejections, bad pids, and no-op requests on an empty table.
    plan.push_back(typed_row(item_row(MODE_ALLOC, 8'd0, 32'hFFFF_FFFF, 16'd10, 16'd10,
                                      16'd0, 16'd0, 16'd0), STAT_BAD_HEADER, 8'd0, 16'd0));
    plan.push_back(typed_row(item_row(MODE_ALLOC, 8'd0, HEADER_MAGIC, 16'hFFFF, 16'hFFFF,
                                      16'd0, 16'd0, 16'd0), STAT_NO_MEM, 8'd0, 16'd0));
    plan.push_back(typed_row(item_row(MODE_EXIT, 8'd255, '0, '0, '0, '0, '0, '0),
                             STAT_BAD_PID, 8'd255, 16'd0));
    plan.push_back(typed_row(item_row(MODE_LOADED, 8'd8, '0, '0, '0, '0, '0, '0),
                             STAT_BAD_PID, 8'd8, 16'd0));
    plan.push_back(typed_row(item_row(MODE_EXIT, 8'd3, '0, '0, '0, '0, '0, '0),
                             STAT_OK, 8'd3, 16'd0));
    plan.push_back(typed_row(item_row(MODE_LOADED, 8'd0, '0, '0, '0, '0, '0, '0),
                             STAT_OK, 8'd0, 16'd0));
    // Three processes: all hooks, exit hook only, and hooks that wrap around.
    plan.push_back(typed_row(item_row(MODE_ALLOC, 8'd0, HEADER_MAGIC, 16'd64, 16'd36,
                                      16'd4, 16'd12, 16'd8), STAT_OK, 8'd0, 16'd0));
    plan.push_back(item_row(MODE_ALLOC, 8'd0, HEADER_MAGIC, 16'd100, 16'd0,
                            16'd0, 16'd0, 16'd16));
    plan.push_back(item_row(MODE_ALLOC, 8'd0, HEADER_MAGIC, 16'd0, 16'd100,
                            16'hFFFF, 16'hFFFF, 16'hFFFF));
    for (int p = 0; p < 3; p++) begin
      plan.push_back(item_row(MODE_LOADED, PID_W'(p), '0, '0, '0, '0, '0, '0));
    end
    for (int p = 0; p < 3; p++) begin
      plan.push_back(item_row(MODE_RUN, '0, '0, '0, '0, '0, '0, '0));
    end
    // Moving the base up puts the free gap of slot 1 behind its own offset.
    plan.push_back(cfg_row(REG_APP_RAM_BASE, 16'd150));
    plan.push_back(item_row(MODE_ALLOC, 8'd0, HEADER_MAGIC, 16'd50, 16'd50,
                            16'd65186, 16'd1, 16'd0));
    plan.push_back(item_row(MODE_LOADED, 8'd3, '0, '0, '0, '0, '0, '0));
    plan.push_back(item_row(MODE_RUN, '0, '0, '0, '0, '0, '0, '0));
    plan.push_back(item_row(MODE_EXIT, 8'd2, '0, '0, '0, '0, '0, '0));
    plan.push_back(item_row(MODE_RUN, '0, '0, '0, '0, '0, '0, '0));
    plan.push_back(cfg_row(REG_APP_RAM_BASE, 16'hFFFF));
    plan.push_back(cfg_row(REG_APP_RAM_SIZE, 16'd0));
    plan.push_back(item_row(MODE_ALLOC, 8'd0, HEADER_MAGIC, 16'd0, 16'd0,
                            16'd1, 16'd0, 16'd0));
    plan.push_back(item_row(MODE_RUN, '0, '0, '0, '0, '0, '0, '0));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        in_tvalid <= 1'b0;
        wait_drained(2);
        write_reg(plan[k].cfg_reg, plan[k].cfg_val);
      end else begin
        send_request(plan[k].req, pick_gap(), plan[k].typed, plan[k].want);
      end
    end

    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      in_tvalid <= 1'b0;
      wait_drained(2);
      calm <= (ph == 5);
      case (ph)
        0: begin
          write_reg(REG_APP_RAM_BASE, 16'h1000);
          write_reg(REG_APP_RAM_SIZE, 16'd8192);
        end
        1: begin
          write_reg(REG_APP_RAM_BASE, 16'hFFFF);
          write_reg(REG_APP_RAM_SIZE, 16'hFFFF);
        end
        2: begin
          write_reg(REG_APP_RAM_BASE, 16'h0000);
          write_reg(REG_APP_RAM_SIZE, 16'h0000);
        end
        3: begin
          write_reg(REG_APP_RAM_BASE, CFG_DATA_W'($urandom));
          write_reg(REG_APP_RAM_SIZE, 16'd600);
        end
        4: begin
          write_reg(REG_APP_RAM_BASE, CFG_DATA_W'($urandom));
          write_reg(REG_APP_RAM_SIZE, CFG_DATA_W'($urandom));
        end
        5: begin
          write_reg(REG_APP_RAM_BASE, 16'hFF00);
          write_reg(REG_APP_RAM_SIZE, 16'd4096);
        end
        6: begin
          write_reg(REG_APP_RAM_BASE, CFG_DATA_W'($urandom));
          write_reg(REG_APP_RAM_SIZE, CFG_DATA_W'($urandom_range(256, 20000)));
        end
        default: begin
          write_reg(REG_APP_RAM_BASE, 16'h0000);
          write_reg(REG_APP_RAM_SIZE, APP_RAM_SIZE_RESET);
        end
      endcase
      // The result side stops for a while and the block backs up into its input.
      if (ph == 3) begin
        hold_start <= 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), pick_gap(), 1'b0, no_result);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained(DRAIN_CYCLES);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered, count", '0, pending_results.size());
    end

    $display("Sent %0d requests and checked %0d results: %0d allocations granted, %0d refused.",
             accepted, checked, granted, refused);
    $display("Ran %0d scheduling passes over %0d register writes, with a %0d-cycle output stall.",
             passes, cfg_writes, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/psa_pkg.sv
src/psa_slot_table.sv
src/process_slot_allocator_scheduler_top.sv
src/psa_checker.sv
dv/process_slot_allocator_scheduler_top_test.sv
